// ===== sv/jcdr_pkg.sv =====
// Shared types, constants and register map of the joystick calibration reporter.
package jcdr_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PACK_W      = CHANNELS * SAMPLE_BITS;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int PERIOD_W    = 16;
  localparam int PDATA_W     = 64;
  localparam int PADDR_W     = 6;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_RAW_MIN  = 3'd0;
  localparam logic [2:0] REG_RAW_MAX  = 3'd1;
  localparam logic [2:0] REG_NEUTRAL  = 3'd2;
  localparam logic [2:0] REG_DEADZONE = 3'd3;
  localparam logic [2:0] REG_PERIOD   = 3'd4;

  // Reset values
  localparam logic [PACK_W-1:0]      RAW_MIN_RESET  = 48'd481153810440;
  localparam logic [PACK_W-1:0]      RAW_MAX_RESET  = 48'd206208774147000;
  localparam logic [SAMPLE_BITS-1:0] NEUTRAL_RESET  = 12'd2048;
  localparam logic [SAMPLE_BITS-1:0] DEADZONE_RESET = 12'd200;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET   = 16'd1000;

  typedef struct packed {
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] raw_min;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] raw_max;
    logic [SAMPLE_BITS-1:0]               neutral;
    logic [SAMPLE_BITS-1:0]               deadzone;
    logic [PERIOD_W-1:0]                  period;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic [PROD_W-1:0]      dividend;
    logic [SAMPLE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [SAMPLE_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/jcdr_regs.sv =====
// APB configuration register file of the joystick calibration reporter.
module jcdr_regs
  import jcdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite & pready;

  // Write registers on the access cycle of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_min  <= RAW_MIN_RESET;
      cfg.raw_max  <= RAW_MAX_RESET;
      cfg.neutral  <= NEUTRAL_RESET;
      cfg.deadzone <= DEADZONE_RESET;
      cfg.period   <= PERIOD_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_RAW_MIN:  cfg.raw_min  <= pwdata[PACK_W-1:0];
        REG_RAW_MAX:  cfg.raw_max  <= pwdata[PACK_W-1:0];
        REG_NEUTRAL:  cfg.neutral  <= pwdata[SAMPLE_BITS-1:0];
        REG_DEADZONE: cfg.deadzone <= pwdata[SAMPLE_BITS-1:0];
        REG_PERIOD:   cfg.period   <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_RAW_MIN:  prdata = PDATA_W'(cfg.raw_min);
      REG_RAW_MAX:  prdata = PDATA_W'(cfg.raw_max);
      REG_NEUTRAL:  prdata = PDATA_W'(cfg.neutral);
      REG_DEADZONE: prdata = PDATA_W'(cfg.deadzone);
      REG_PERIOD:   prdata = PDATA_W'(cfg.period);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== sv/jcdr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module jcdr_div
  import jcdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS = SAMPLE_BITS;
  localparam int CNT_W = $clog2(STEPS);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] low;
  logic [SAMPLE_BITS-1:0] quo;
  logic [SAMPLE_BITS-1:0] dvs;
  logic [SAMPLE_BITS:0]   trial;
  logic                   take;

  // Quotient fits SAMPLE_BITS since the caller keeps dividend < divisor << SAMPLE_BITS
  assign trial = {rem, low[SAMPLE_BITS-1]};
  assign take  = (trial >= {1'b0, dvs});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[PROD_W-1:SAMPLE_BITS];
      low <= req.dividend[SAMPLE_BITS-1:0];
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? SAMPLE_BITS'(trial - {1'b0, dvs}) : trial[SAMPLE_BITS-1:0];
      low <= {low[SAMPLE_BITS-2:0], 1'b0};
      quo <= {quo[SAMPLE_BITS-2:0], take};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== sv/joystick_calibrate_deadzone_report.sv =====
// Top level: joystick calibration, deadzone check and report output.
//
// Input stream (s_axis_*): one transaction carries four raw 12-bit samples.
// Output stream (m_axis_*): zero or one report per input transaction.
// Config: APB port, 64-bit data, register i at byte address 8*i.
//
// Every input bumps a tick counter. Inputs that are not a check item are
// taken back to back; tready stays high for them. A check item (tick
// reaches report_period) runs the four channels one after another through
// one 12-step restoring divider, which a channel skips when no division is
// needed. tready stays low through S_CHAN, S_DIV and S_ACC for each channel
// and then S_EMIT, until the block is back in S_IDLE for the next accept.
// A report is an active one (tuser 0, scaled values) when any channel leaves
// the deadzone, else a neutral one (tuser 1, zero data) once per idle run.
// The report sits in an output register; the next input is accepted while
// it waits. If a new report is due while the register is still full, the
// block holds until the receiver takes the old one.
// Reset (rst, synchronous) clears the counter, the neutral flag and the
// output valid and loads the register defaults.
module joystick_calibrate_deadzone_report
  import jcdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PACK_W-1:0]  s_axis_tdata,  // raw_ch0, raw_ch1, raw_ch2, raw_ch3
  // Output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PACK_W-1:0]  m_axis_tdata,  // scaled_ch0, scaled_ch1, scaled_ch2, scaled_ch3
  output logic               m_axis_tuser   // report_kind
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]                           state;
  logic [PERIOD_W-1:0]                  tick_count;
  logic [PERIOD_W-1:0]                  tick_next;
  logic                                 neutral_sent;
  logic                                 active;
  logic [CH_W-1:0]                      ch;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] raw;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0]               cur;

  logic [SAMPLE_BITS-1:0] raw_sel;
  logic [SAMPLE_BITS-1:0] lo_sel;
  logic [SAMPLE_BITS-1:0] hi_sel;
  logic [SAMPLE_BITS-1:0] span;
  logic [SAMPLE_BITS-1:0] offset;
  logic [SAMPLE_BITS-1:0] dev;
  logic                   in_fire;
  logic                   report_due;
  logic                   out_free;

  jcdr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jcdr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign tick_next     = tick_count + 1'b1;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign report_due    = active | ~neutral_sent;

  // Current channel operands
  assign raw_sel = raw[ch];
  assign lo_sel  = cfg.raw_min[ch];
  assign hi_sel  = cfg.raw_max[ch];
  assign span    = hi_sel - lo_sel;
  assign offset  = raw_sel - lo_sel;

  // Divider request: (raw - min) * full scale over (max - min)
  assign div_req.start    = (state == S_CHAN) && (hi_sel > lo_sel) &&
                            (raw_sel > lo_sel) && (raw_sel < hi_sel);
  assign div_req.dividend = PROD_W'(offset) * PROD_W'(FULL_SCALE);
  assign div_req.divisor  = span;

  // Distance of the current channel from neutral
  assign dev = (cur >= cfg.neutral) ? cur - cfg.neutral : cfg.neutral - cur;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_count   <= '0;
      neutral_sent <= 1'b0;
      active       <= 1'b0;
      ch           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (tick_next < cfg.period) begin
              tick_count <= tick_next;
            end else begin
              tick_count <= '0;
              active     <= 1'b0;
              ch         <= '0;
              state      <= S_CHAN;
            end
          end
        end
        S_CHAN: begin
          if (div_req.start) begin
            state <= S_DIV;
          end else begin
            state <= S_ACC;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (dev > cfg.deadzone) begin
            active <= 1'b1;
          end
          if (ch == CH_W'(CHANNELS - 1)) begin
            state <= S_EMIT;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_CHAN;
          end
        end
        S_EMIT: begin
          if (!report_due) begin
            state <= S_IDLE;
          end else if (out_free) begin
            neutral_sent <= ~active;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture samples and per-channel results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw <= s_axis_tdata;
    end
    if (state == S_CHAN && !div_req.start) begin
      cur        <= (hi_sel <= lo_sel || raw_sel <= lo_sel) ? '0 : FULL_SCALE;
      scaled[ch] <= (hi_sel <= lo_sel || raw_sel <= lo_sel) ? '0 : FULL_SCALE;
    end else if (state == S_DIV && div_rsp.done) begin
      cur        <= div_rsp.quotient;
      scaled[ch] <= div_rsp.quotient;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_EMIT && report_due && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && report_due && out_free) begin
      m_axis_tuser <= ~active;
      m_axis_tdata <= active ? scaled : '0;
    end
  end

  // Checks
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_neutral_empty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("neutral report carries data");

  a_tick_cleared: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (tick_count == '0))
    else $error("tick counter not cleared during a check");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_EMIT))
    else $error("report loaded outside emit");

endmodule
